// ----- sv/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the servo endpoint mapper
// Beat payloads, command codes, calibration phase encoding and default ends.
// ----------------------------------------------------------------------------
package sem_pkg;

  // Command codes carried on an input beat
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_ABORT  = 2'd2;

  // Phase codes as seen on the result beat
  localparam logic [1:0] PHC_OFF    = 2'd0;
  localparam logic [1:0] PHC_LEFT   = 2'd1;
  localparam logic [1:0] PHC_CENTRE = 2'd2;
  localparam logic [1:0] PHC_RIGHT  = 2'd3;

  // Default endpoints in microseconds
  localparam logic [15:0] DEF_LEFT   = 16'd900;
  localparam logic [15:0] DEF_CENTRE = 16'd1500;
  localparam logic [15:0] DEF_RIGHT  = 16'd2100;

  // Divide by 100: x < 2^23, so ceil(2^30 / 100) with a 30-bit shift is exact
  localparam int unsigned PCT_FULL  = 100;
  localparam int unsigned DIV_SHIFT = 30;
  localparam logic [23:0] DIV_MUL   = 24'(((64'd1 << DIV_SHIFT) + PCT_FULL - 1) / PCT_FULL);

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [7:0] stick_percent;
    logic              confirm;
  } item_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic [1:0]  cal_phase;
    logic        cal_done;
  } result_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] centre;
    logic [15:0] right;
  } ends_t;

  localparam ends_t DEF_ENDS = '{left: DEF_LEFT, centre: DEF_CENTRE, right: DEF_RIGHT};

  // Calibration phase, one-hot
  typedef enum logic [3:0] {
    PH_OFF    = 4'b0001,
    PH_LEFT   = 4'b0010,
    PH_CENTRE = 4'b0100,
    PH_RIGHT  = 4'b1000
  } phase_t;

  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_LEFT:   code = PHC_LEFT;
      PH_CENTRE: code = PHC_CENTRE;
      PH_RIGHT:  code = PHC_RIGHT;
      default:   code = PHC_OFF;
    endcase
    return code;
  endfunction

endpackage

// ----- sv/sem_map.sv -----
// ----------------------------------------------------------------------------
// sem_map: stick to pulse width mapping
// Piecewise linear through three endpoints, signed slope, truncation toward
// zero, result wrapped to 16 bits. Purely combinational.
// ----------------------------------------------------------------------------
module sem_map (
  input  sem_pkg::ends_t    ends,
  input  logic signed [7:0] stick_percent,
  output logic [15:0]       pulse_width
);
  import sem_pkg::*;

  logic        neg;
  logic [16:0] diff;
  logic [16:0] diff_neg;
  logic [15:0] abs_diff;
  logic [7:0]  mag_pct;
  logic [23:0] prod;
  logic [46:0] prod_m;
  logic [15:0] quot;
  logic [15:0] delta;

  // Pick the side and its signed span
  assign neg  = stick_percent[7];
  assign diff = neg ? ({1'b0, ends.centre} - {1'b0, ends.left})
                    : ({1'b0, ends.right} - {1'b0, ends.centre});
  assign diff_neg = 17'(~diff + 17'd1);
  assign abs_diff = diff[16] ? diff_neg[15:0] : diff[15:0];
  assign mag_pct  = neg ? 8'(~stick_percent + 8'sd1) : 8'(stick_percent);

  // Magnitude product, then divide by 100 through the reciprocal
  assign prod   = 24'(abs_diff) * 24'(mag_pct);
  assign prod_m = 47'(prod) * 47'(DIV_MUL);
  assign quot   = prod_m[DIV_SHIFT +: 16];

  // Restore the sign of the span and apply about the centre, mod 2^16
  assign delta       = diff[16] ? 16'(~quot + 16'd1) : quot;
  assign pulse_width = neg ? 16'(ends.centre - delta) : 16'(ends.centre + delta);

endmodule

// ----- sv/sem_cal.sv -----
// ----------------------------------------------------------------------------
// sem_cal: calibration state and per-beat update
// Holds the live and saved endpoints and the capture phase; works out the
// result for the beat on its input and updates state when fire is high.
// ----------------------------------------------------------------------------
module sem_cal (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sem_pkg::item_t    item,
  output sem_pkg::result_t  result
);
  import sem_pkg::*;

  phase_t      phase, phase_next;
  ends_t       ends, ends_next;
  ends_t       saved, saved_next;
  logic [15:0] cap_left, cap_left_next;
  logic [15:0] cap_centre, cap_centre_next;
  ends_t       ends_sel;
  logic [15:0] pulse;
  logic        done;

  // Endpoints that this beat maps with
  always_comb begin
    case (item.cmd)
      CMD_START: ends_sel = DEF_ENDS;
      CMD_ABORT: ends_sel = saved;
      default:   ends_sel = ends;
    endcase
  end

  sem_map u_map (
    .ends          (ends_sel),
    .stick_percent (item.stick_percent),
    .pulse_width   (pulse)
  );

  // Phase sequencing and captures
  always_comb begin
    phase_next      = phase;
    ends_next       = ends_sel;
    saved_next      = saved;
    cap_left_next   = cap_left;
    cap_centre_next = cap_centre;
    done            = 1'b0;
    case (item.cmd)
      CMD_START: phase_next = PH_LEFT;
      CMD_ABORT: phase_next = PH_OFF;
      default: begin
        if (item.confirm) begin
          case (phase)
            PH_LEFT: begin
              cap_left_next = pulse;
              phase_next    = PH_CENTRE;
            end
            PH_CENTRE: begin
              cap_centre_next = pulse;
              phase_next      = PH_RIGHT;
            end
            PH_RIGHT: begin
              ends_next  = '{left: cap_left, centre: cap_centre, right: pulse};
              saved_next = '{left: cap_left, centre: cap_centre, right: pulse};
              phase_next = PH_OFF;
              done       = 1'b1;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  assign result = '{pulse_width: pulse, cal_phase: phase_code(phase_next), cal_done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OFF;
      ends       <= DEF_ENDS;
      saved      <= DEF_ENDS;
      cap_left   <= '0;
      cap_centre <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      ends       <= ends_next;
      saved      <= saved_next;
      cap_left   <= cap_left_next;
      cap_centre <= cap_centre_next;
    end
  end

endmodule

// ----- sv/servo_endpoint_calibration_mapper_core.sv -----
// An accepted input beat goes through the input register and then the result register.
// Throughput: one beat per cycle while the result side is not stalled; mapping,
// capture and endpoint update are combinational between the input and result registers.
// One extra beat is taken while a finished result is held by stall.
// Reset (synchronous): pipe empty, calibration off, endpoints and saved copy
// at 900 / 1500 / 2100, captures cleared.
// ----------------------------------------------------------------------------
// servo_endpoint_calibration_mapper_core: top level
// Input register, calibration/mapping stage and result register.
// ----------------------------------------------------------------------------
module servo_endpoint_calibration_mapper_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sem_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sem_pkg::result_t result
);
  import sem_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    out_free;
  logic    fire;
  result_t res_next;

  // Pipe control
  assign out_free   = !result_valid || !result_stall;
  assign fire       = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
  end

  sem_cal u_cal (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

endmodule

// ----- sv/sem_checker.sv -----
// ----------------------------------------------------------------------------
// sem_checker: port-level checks for the servo endpoint mapper
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module sem_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input sem_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input sem_pkg::result_t result
);
  import sem_pkg::*;

  // A stalled input beat stays offered and unchanged
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("input beat changed while stalled");

  // A held result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // A commit always leaves calibration off
  a_done_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cal_done |-> result.cal_phase == PHC_OFF)
    else $error("cal_done with calibration still running");

  // Input only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with room downstream");

  // Reset empties the pipe
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("pipe not empty after reset");

endmodule

bind servo_endpoint_calibration_mapper_core sem_checker u_sem_checker (.*);

// ----- verif/servo_endpoint_calibration_mapper_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_endpoint_calibration_mapper_core_tb: self-checking testbench
// Drives stick samples and calibration commands through the valid/stall input
// channel, predicts each result beat with an in-bench model of the mapper and
// the calibration sequencer, and checks every result field in order. A short
// table of directed rows comes first, then random calibration sequences mixed
// with noise. Both sides idle at random, with one long receiver hold-off and
// one full drain of the pipe along the way.
// ----------------------------------------------------------------------------
module servo_endpoint_calibration_mapper_core_tb;
  import sem_pkg::*;

  // Unnamed command code, treated by the block as a sample tick
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int RAND_ITEMS   = 400;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_AT      = 150;
  localparam int DRAIN_AT     = 260;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    item_t   beat;
    bit      typed;
    result_t res;
  } stim_row_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  // Predictor state
  logic [1:0] cal_phase;
  ends_t      ends;
  ends_t      saved_ends;
  logic [15:0] cap_left;
  logic [15:0] cap_centre;

  result_t   due_results[$];
  stim_row_t stim_table[$];
  int        mismatch_count;
  int        beats_sent;
  bit        tx_idle_en;
  bit        rx_idle_en;
  bit        hold_req;

  servo_endpoint_calibration_mapper_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Piecewise linear map through left / centre / right, truncating divide
  function automatic logic [15:0] stick_to_pulse(ends_t e, logic signed [7:0] pct);
    int c;
    int span;
    int delta;
    c = int'(e.centre);
    if (pct < 0) begin
      span  = c - int'(e.left);
      delta = (span * (-int'(pct))) / int'(PCT_FULL);
      return 16'(c - delta);
    end
    span  = int'(e.right) - c;
    delta = (span * int'(pct)) / int'(PCT_FULL);
    return 16'(c + delta);
  endfunction

  // One beat through the calibration sequencer; updates predictor state
  function automatic result_t calib_map_step(item_t it);
    result_t r;
    r.cal_done = 1'b0;
    case (it.cmd)
      CMD_START: begin
        ends          = DEF_ENDS;
        cal_phase     = PHC_LEFT;
        r.pulse_width = stick_to_pulse(ends, it.stick_percent);
      end
      CMD_ABORT: begin
        cal_phase     = PHC_OFF;
        ends          = saved_ends;
        r.pulse_width = stick_to_pulse(ends, it.stick_percent);
      end
      default: begin
        r.pulse_width = stick_to_pulse(ends, it.stick_percent);
        if (cal_phase != PHC_OFF && it.confirm) begin
          case (cal_phase)
            PHC_LEFT: begin
              cap_left  = r.pulse_width;
              cal_phase = PHC_CENTRE;
            end
            PHC_CENTRE: begin
              cap_centre = r.pulse_width;
              cal_phase  = PHC_RIGHT;
            end
            default: begin
              ends       = '{left: cap_left, centre: cap_centre, right: r.pulse_width};
              saved_ends = ends;
              cal_phase  = PHC_OFF;
              r.cal_done = 1'b1;
            end
          endcase
        end
      end
    endcase
    r.cal_phase = cal_phase;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic add_row(logic [1:0] cmd, int stick, bit conf, bit typed,
                         int pw, logic [1:0] ph, bit done);
    stim_row_t row;
    row.beat  = '{cmd: cmd, stick_percent: 8'(stick), confirm: conf};
    row.typed = typed;
    row.res   = '{pulse_width: 16'(pw), cal_phase: ph, cal_done: done};
    stim_table.push_back(row);
  endtask

  function automatic logic [7:0] rand_stick();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return 8'(int'($urandom_range(0, 200)) - 100);
  endfunction

  // Offer one beat, wait for it to be taken, then queue its expected result
  task automatic send_beat(item_t it, bit typed, result_t typed_res);
    result_t predicted;
    if (tx_idle_en && !hold_req && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predicted = calib_map_step(it);
    due_results.push_back(typed ? typed_res : predicted);
    beats_sent++;
  endtask

  task automatic send_rand(logic [1:0] cmd, bit conf);
    item_t it;
    it = '{cmd: cmd, stick_percent: rand_stick(), confirm: conf};
    send_beat(it, 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    int   rand_start;
    bit   hold_issued;
    bit   drain_issued;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    mismatch_count = 0;
    beats_sent     = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    hold_req       = 1'b0;
    hold_issued    = 1'b0;
    drain_issued   = 1'b0;
    cal_phase      = PHC_OFF;
    ends           = DEF_ENDS;
    saved_ends     = DEF_ENDS;
    cap_left       = '0;
    cap_centre     = '0;

    // Defaults after reset, stick extremes, confirm while off, spare code
    add_row(CMD_SAMPLE,    0, 1'b0, 1'b1, 1500, PHC_OFF, 1'b0);
    add_row(CMD_SAMPLE,  100, 1'b0, 1'b1, 2100, PHC_OFF, 1'b0);
    add_row(CMD_SAMPLE, -100, 1'b0, 1'b1,  900, PHC_OFF, 1'b0);
    add_row(CMD_SAMPLE,  127, 1'b0, 1'b1, 2262, PHC_OFF, 1'b0);
    add_row(CMD_SAMPLE, -128, 1'b0, 1'b1,  732, PHC_OFF, 1'b0);
    add_row(CMD_SAMPLE,   50, 1'b1, 1'b1, 1800, PHC_OFF, 1'b0);
    add_row(CMD_SPARE,     0, 1'b0, 1'b1, 1500, PHC_OFF, 1'b0);
    // Full calibration at defaults; start ignores confirm
    add_row(CMD_START,     0, 1'b1, 1'b1, 1500, PHC_LEFT,   1'b0);
    add_row(CMD_SAMPLE, -100, 1'b1, 1'b1,  900, PHC_CENTRE, 1'b0);
    add_row(CMD_SAMPLE,   30, 1'b0, 1'b0,    0, PHC_OFF,    1'b0);
    add_row(CMD_SAMPLE,    0, 1'b1, 1'b1, 1500, PHC_RIGHT,  1'b0);
    add_row(CMD_SPARE,   100, 1'b1, 1'b1, 2100, PHC_OFF,    1'b1);
    // Skewed calibration: centre above right gives a negative span
    add_row(CMD_START,  -100, 1'b1, 1'b1,  900, PHC_LEFT,   1'b0);
    add_row(CMD_SAMPLE, -128, 1'b1, 1'b1,  732, PHC_CENTRE, 1'b0);
    add_row(CMD_SAMPLE,  127, 1'b1, 1'b1, 2262, PHC_RIGHT,  1'b0);
    add_row(CMD_SAMPLE,    1, 1'b1, 1'b0,    0, PHC_OFF,    1'b0);
    add_row(CMD_SAMPLE,  100, 1'b0, 1'b0,    0, PHC_OFF,    1'b0);
    add_row(CMD_SAMPLE,   -1, 1'b0, 1'b0,    0, PHC_OFF,    1'b0);
    // Abort mid-calibration restores the saved ends, abort while off too
    add_row(CMD_START,     0, 1'b0, 1'b1, 1500, PHC_LEFT,   1'b0);
    add_row(CMD_SAMPLE, -100, 1'b1, 1'b1,  900, PHC_CENTRE, 1'b0);
    add_row(CMD_ABORT,   100, 1'b1, 1'b0,    0, PHC_OFF,    1'b0);
    add_row(CMD_ABORT,     0, 1'b0, 1'b0,    0, PHC_OFF,    1'b0);
    add_row(CMD_SAMPLE, -128, 1'b1, 1'b0,    0, PHC_OFF,    1'b0);
    add_row(CMD_SAMPLE,  127, 1'b0, 1'b0,    0, PHC_OFF,    1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_beat(stim_table[i].beat, stim_table[i].typed,
                                      stim_table[i].res);

    // Random calibration sequences with noise in between
    rand_start = beats_sent;
    while (beats_sent - rand_start < RAND_ITEMS) begin
      if (beats_sent - rand_start >= RAND_ITEMS - QUIET_ITEMS) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (!hold_issued && beats_sent - rand_start >= HOLD_AT) begin
        hold_issued = 1'b1;
        hold_req    = 1'b1;
      end
      if (!drain_issued && beats_sent - rand_start >= DRAIN_AT) begin
        drain_issued = 1'b1;
        item_valid <= 1'b0;
        wait (due_results.size() == 0);
        @(posedge clk);
      end
      if ($urandom_range(0, 9) < 7) begin
        send_rand(CMD_START, 1'($urandom_range(0, 1)));
        for (int step = 0; step < 3; step++) begin
          repeat ($urandom_range(0, 2))
            send_rand($urandom_range(0, 1) ? CMD_SAMPLE : CMD_SPARE, 1'b0);
          if ($urandom_range(0, 11) == 0) begin
            send_rand(CMD_ABORT, 1'($urandom_range(0, 1)));
            break;
          end
          send_rand($urandom_range(0, 3) == 0 ? CMD_SPARE : CMD_SAMPLE, 1'b1);
        end
      end else begin
        repeat ($urandom_range(1, 4))
          send_rand(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
    item_valid <= 1'b0;

    // Drain, then let the pipe settle
    wait (due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("result beats outstanding", due_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver stall: random bursts, plus one long hold-off on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Result checker: compare each taken beat with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result beat, pulse_width", result.pulse_width, 0);
      end else begin
        want = due_results.pop_front();
        if (result.pulse_width !== want.pulse_width)
          report_mismatch("pulse_width", result.pulse_width, want.pulse_width);
        if (result.cal_phase !== want.cal_phase)
          report_mismatch("cal_phase", result.cal_phase, want.cal_phase);
        if (result.cal_done !== want.cal_done)
          report_mismatch("cal_done", result.cal_done, want.cal_done);
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/sem_pkg.sv
sv/sem_map.sv
sv/sem_cal.sv
sv/servo_endpoint_calibration_mapper_core.sv
sv/sem_checker.sv
verif/servo_endpoint_calibration_mapper_core_tb.sv
